[hdl/mea_pkg.sv]
`timescale 1ns / 1ps
package mea_pkg;

   localparam int COORD_WIDTH_DEF     = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int CORDIC_STEPS_DEF    = 16;

   localparam int ACC_FRAC    = 24;
   localparam int TABLE_LEN   = 24;
   localparam int Z_WIDTH     = 32;
   localparam int ANGLE_WIDTH = 18;

   localparam int DEG_COIN    = -333;
   localparam int DEG_HALF    = 180;
   localparam int DEG_QUARTER = 90;

   // atan(2^-i) in degrees, 24 fractional bits
   localparam logic signed [Z_WIDTH-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
      32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
      32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509719,
      32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
      32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
      32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
      32'sd917,       32'sd458,       32'sd229,       32'sd115
   };

   typedef struct packed {
      logic                   special;
      logic                   coincident;
      logic                   dx_neg;
      logic                   dy_neg;
      logic [ANGLE_WIDTH-1:0] special_angle;
   } side_type;

endpackage

[hdl/mea_req_if.sv]
`timescale 1ns / 1ps
interface mea_req_if #(
   parameter int COORD_WIDTH = mea_pkg::COORD_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] first_x;
   logic [COORD_WIDTH-1:0] first_y;
   logic [COORD_WIDTH-1:0] second_x;
   logic [COORD_WIDTH-1:0] second_y;

   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

[hdl/mea_rsp_if.sv]
`timescale 1ns / 1ps
interface mea_rsp_if;
   import mea_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] angle;
   logic                          coincident;

   modport source (output valid, angle, coincident, input ready);
   modport sink   (input valid, angle, coincident, output ready);
endinterface

[hdl/mea_prep.sv]
`timescale 1ns / 1ps
module mea_prep #(
   parameter int COORD_WIDTH     = mea_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = mea_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int STEPS           = mea_pkg::CORDIC_STEPS_DEF,
   parameter int VEC_WIDTH       = COORD_WIDTH + STEPS + 3
) (
   input  logic                        clock,
   input  logic                        reset,
   mea_req_if.sink                     req_chan,
   output logic                        valid_out,
   input  logic                        ready_in,
   output logic signed [VEC_WIDTH-1:0] x_out,
   output logic signed [VEC_WIDTH-1:0] y_out,
   output mea_pkg::side_type           side_out
);
   import mea_pkg::*;

   localparam int ONE     = 1 << ANGLE_FRAC_BITS;
   localparam int A_COIN  = DEG_COIN * ONE;
   localparam int A_HALF  = DEG_HALF * ONE;
   localparam int A_QUART = DEG_QUARTER * ONE;
   localparam int A_NQUART = -DEG_QUARTER * ONE;

   logic signed [COORD_WIDTH:0]   dx, dy;
   logic [COORD_WIDTH-1:0]        abs_dx, abs_dy;
   logic                          dx_zero, dy_zero;
   logic                          ready_out;
   logic                          valid_ff, valid_in;
   logic signed [VEC_WIDTH-1:0]   x_ff, x_in, y_ff, y_in;
   side_type                      side_ff, side_in;

   assign ready_out      = !valid_ff || ready_in;
   assign req_chan.ready = ready_out;

   always_comb begin
      dx = signed'({1'b0, req_chan.second_x}) - signed'({1'b0, req_chan.first_x});
      dy = signed'({1'b0, req_chan.second_y}) - signed'({1'b0, req_chan.first_y});
      abs_dx  = dx[COORD_WIDTH] ? COORD_WIDTH'(-dx) : COORD_WIDTH'(dx);
      abs_dy  = dy[COORD_WIDTH] ? COORD_WIDTH'(-dy) : COORD_WIDTH'(dy);
      dx_zero = (dx == '0);
      dy_zero = (dy == '0);
      x_in = {3'b000, abs_dx, {STEPS{1'b0}}};
      y_in = {3'b000, abs_dy, {STEPS{1'b0}}};
      side_in.special    = dx_zero || dy_zero;
      side_in.coincident = dx_zero && dy_zero;
      side_in.dx_neg     = dx[COORD_WIDTH];
      side_in.dy_neg     = dy[COORD_WIDTH];
      if (dx_zero && dy_zero) begin
         side_in.special_angle = ANGLE_WIDTH'(A_COIN);
      end else if (dy_zero) begin
         side_in.special_angle = dx[COORD_WIDTH] ? ANGLE_WIDTH'(A_HALF) : '0;
      end else begin
         side_in.special_angle = dy[COORD_WIDTH] ? ANGLE_WIDTH'(A_NQUART)
                                                 : ANGLE_WIDTH'(A_QUART);
      end
      valid_in = ready_out ? req_chan.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && req_chan.valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign side_out  = side_ff;

   a_coin_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && side_ff.coincident |-> x_ff == '0 && y_ff == '0)
      else $error("coincident beat with non-zero vector");

endmodule

[hdl/mea_cell.sv]
`timescale 1ns / 1ps
module mea_cell #(
   parameter int VEC_WIDTH = mea_pkg::COORD_WIDTH_DEF + mea_pkg::CORDIC_STEPS_DEF + 3,
   parameter int STEP      = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   output logic                               ready_out,
   input  logic signed [VEC_WIDTH-1:0]        x_in,
   input  logic signed [VEC_WIDTH-1:0]        y_in,
   input  logic signed [mea_pkg::Z_WIDTH-1:0] z_in,
   input  mea_pkg::side_type                  side_in,
   output logic                               valid_out,
   input  logic                               ready_in,
   output logic signed [VEC_WIDTH-1:0]        x_out,
   output logic signed [VEC_WIDTH-1:0]        y_out,
   output logic signed [mea_pkg::Z_WIDTH-1:0] z_out,
   output mea_pkg::side_type                  side_out
);
   import mea_pkg::*;

   logic                        valid_ff, valid_nx;
   logic signed [VEC_WIDTH-1:0] xs, ys;
   logic signed [VEC_WIDTH-1:0] x_ff, x_nx, y_ff, y_nx;
   logic signed [Z_WIDTH-1:0]   z_ff, z_nx;
   side_type                    side_ff;

   assign ready_out = !valid_ff || ready_in;

   always_comb begin
      xs = x_in >>> STEP;
      ys = y_in >>> STEP;
      if (!y_in[VEC_WIDTH-1]) begin
         x_nx = x_in + ys;
         y_nx = y_in - xs;
         z_nx = z_in + ATAN_TAB[STEP];
      end else begin
         x_nx = x_in - ys;
         y_nx = y_in + xs;
         z_nx = z_in - ATAN_TAB[STEP];
      end
      valid_nx = ready_out ? valid_in : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         x_ff    <= x_nx;
         y_ff    <= y_nx;
         z_ff    <= z_nx;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;

   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !x_ff[VEC_WIDTH-1])
      else $error("cordic x went negative");

endmodule

[hdl/mea_finish.sv]
`timescale 1ns / 1ps
module mea_finish #(
   parameter int ANGLE_FRAC_BITS = mea_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   output logic                               ready_out,
   input  logic signed [mea_pkg::Z_WIDTH-1:0] z_in,
   input  mea_pkg::side_type                  side_in,
   mea_rsp_if.source                          rsp_chan
);
   import mea_pkg::*;

   localparam int SHIFT    = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [Z_WIDTH-1:0] LIMIT = Z_WIDTH'(DEG_QUARTER * (1 << ACC_FRAC));
   localparam logic signed [Z_WIDTH-1:0] HALF_LSB = Z_WIDTH'(1 << (SHIFT - 1));
   localparam logic signed [Z_WIDTH-1:0] A_HALF = Z_WIDTH'(DEG_HALF * (1 << ANGLE_FRAC_BITS));
   localparam int A_COIN = DEG_COIN * (1 << ANGLE_FRAC_BITS);

   logic signed [Z_WIDTH-1:0]     zc, t, a;
   logic                          valid_ff, valid_nx;
   logic signed [ANGLE_WIDTH-1:0] angle_ff, angle_nx;
   logic                          coin_ff;

   assign ready_out = !valid_ff || rsp_chan.ready;

   always_comb begin
      if (z_in[Z_WIDTH-1]) begin
         zc = '0;
      end else if (z_in > LIMIT) begin
         zc = LIMIT;
      end else begin
         zc = z_in;
      end
      t = (zc + HALF_LSB) >>> SHIFT;
      if (!side_in.dx_neg) begin
         a = side_in.dy_neg ? -t : t;
      end else begin
         a = side_in.dy_neg ? t - A_HALF : A_HALF - t;
      end
      angle_nx = side_in.special ? side_in.special_angle : a[ANGLE_WIDTH-1:0];
      valid_nx = ready_out ? valid_in : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         angle_ff <= angle_nx;
         coin_ff  <= side_in.coincident;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.angle      = angle_ff;
   assign rsp_chan.coincident = coin_ff;

   a_sentinel: assert property (@(posedge clock) disable iff (reset)
      valid_ff && coin_ff |-> angle_ff == ANGLE_WIDTH'(A_COIN))
      else $error("coincident beat without sentinel angle");

endmodule

[hdl/marker_edge_angle_top.sv]
`timescale 1ns / 1ps
// Pipeline from request beat to response valid: registered difference stage, one cell per
//   CORDIC step, output register.
// Throughput: one beat per cycle; each stage stalls only when the one after it is full.
// Steps are capped at 24, the length of the arctangent table.
// Reset: synchronous, active high; empties every stage, payload is not cleared.
module marker_edge_angle_top #(
   parameter int COORD_WIDTH     = mea_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = mea_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = mea_pkg::CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mea_req_if.sink   req_chan,
   mea_rsp_if.source rsp_chan
);
   import mea_pkg::*;

   localparam int STEPS     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int VEC_WIDTH = COORD_WIDTH + STEPS + 3;

   logic                        valid_w [0:STEPS];
   logic                        ready_w [0:STEPS];
   logic signed [VEC_WIDTH-1:0] x_w     [0:STEPS-1];
   logic signed [VEC_WIDTH-1:0] y_w     [0:STEPS-1];
   logic signed [Z_WIDTH-1:0]   z_w     [1:STEPS];
   side_type                    side_w  [0:STEPS];

   mea_prep #(
      .COORD_WIDTH     (COORD_WIDTH),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .STEPS           (STEPS),
      .VEC_WIDTH       (VEC_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .valid_out (valid_w[0]),
      .ready_in  (ready_w[0]),
      .x_out     (x_w[0]),
      .y_out     (y_w[0]),
      .side_out  (side_w[0])
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      logic signed [Z_WIDTH-1:0] z_src;
      if (i == 0) begin : g_first
         assign z_src = '0;
      end else begin : g_rest
         assign z_src = z_w[i];
      end
      if (i < STEPS - 1) begin : g_mid
         mea_cell #(.VEC_WIDTH(VEC_WIDTH), .STEP(i)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_in  (valid_w[i]),
            .ready_out (ready_w[i]),
            .x_in      (x_w[i]),
            .y_in      (y_w[i]),
            .z_in      (z_src),
            .side_in   (side_w[i]),
            .valid_out (valid_w[i+1]),
            .ready_in  (ready_w[i+1]),
            .x_out     (x_w[i+1]),
            .y_out     (y_w[i+1]),
            .z_out     (z_w[i+1]),
            .side_out  (side_w[i+1])
         );
      end else begin : g_last
         mea_cell #(.VEC_WIDTH(VEC_WIDTH), .STEP(i)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_in  (valid_w[i]),
            .ready_out (ready_w[i]),
            .x_in      (x_w[i]),
            .y_in      (y_w[i]),
            .z_in      (z_src),
            .side_in   (side_w[i]),
            .valid_out (valid_w[i+1]),
            .ready_in  (ready_w[i+1]),
            .x_out     (),
            .y_out     (),
            .z_out     (z_w[i+1]),
            .side_out  (side_w[i+1])
         );
      end
   end

   mea_finish #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (valid_w[STEPS]),
      .ready_out (ready_w[STEPS]),
      .z_in      (z_w[STEPS]),
      .side_in   (side_w[STEPS]),
      .rsp_chan  (rsp_chan)
   );

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("request stalled without response back-pressure");

endmodule

[tb/marker_edge_angle_top_tb.sv]
`timescale 1ns / 1ps
module marker_edge_angle_top_tb;
   import mea_pkg::*;

   localparam int COORD_W      = COORD_WIDTH_DEF;
   localparam int FRAC_BITS    = ANGLE_FRAC_BITS_DEF;
   localparam int STEPS        = (CORDIC_STEPS_DEF > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS_DEF;
   localparam int PIPE_LATENCY = CORDIC_STEPS_DEF + 2;
   localparam int RANDOM_PAIRS = 1300;
   localparam int CALM_TAIL    = 150;
   localparam int HOLD_START   = 300;
   localparam int HOLD_LEN     = 200;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   localparam longint ATAN_DEG [0:TABLE_LEN-1] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509719, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   typedef struct packed {
      logic [COORD_W-1:0] first_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] second_x;
      logic [COORD_W-1:0] second_y;
   } corner_pair_type;

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0] angle;
      logic                   coincident;
   } angle_beat_type;

   logic clock = 1'b0;
   logic reset;

   mea_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   mea_rsp_if rsp_chan ();

   marker_edge_angle_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   corner_pair_type corner_pairs [$];
   angle_beat_type  expected_angles [$];
   corner_pair_type next_pair;
   logic            calm = 1'b0;
   int              idle_left = 0;
   int              stall_left = 0;
   int              hold_left = 0;
   int              run_cycles = 0;
   int              cycle_count = 0;
   int              mismatches = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // vectoring CORDIC on |dx|, |dy|, quadrant restored afterwards
   function automatic angle_beat_type edge_angle(corner_pair_type p);
      longint         dx, dy, x, y, z, xs, ys, t, one, a;
      angle_beat_type r;
      one = longint'(1) << FRAC_BITS;
      dx  = longint'(p.second_x) - longint'(p.first_x);
      dy  = longint'(p.second_y) - longint'(p.first_y);
      r.coincident = 1'b0;
      if (dx == 0 && dy == 0) begin
         a = DEG_COIN * one;
         r.coincident = 1'b1;
      end else if (dy == 0) begin
         a = (dx > 0) ? 0 : DEG_HALF * one;
      end else if (dx == 0) begin
         a = (dy > 0) ? DEG_QUARTER * one : -DEG_QUARTER * one;
      end else begin
         x = ((dx < 0) ? -dx : dx) <<< STEPS;
         y = ((dy < 0) ? -dy : dy) <<< STEPS;
         z = 0;
         for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_DEG[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_DEG[i];
            end
         end
         if (z < 0) z = 0;
         if (z > (longint'(DEG_QUARTER) <<< ACC_FRAC)) z = longint'(DEG_QUARTER) <<< ACC_FRAC;
         t = (z + (longint'(1) <<< (ACC_FRAC - FRAC_BITS - 1))) >>> (ACC_FRAC - FRAC_BITS);
         if (dx > 0) a = (dy > 0) ? t : -t;
         else        a = (dy > 0) ? DEG_HALF * one - t : t - DEG_HALF * one;
      end
      r.angle = a[ANGLE_WIDTH-1:0];
      return r;
   endfunction

   task automatic add_pair(int x0, int y0, int x1, int y1);
      corner_pair_type p;
      p.first_x  = x0[COORD_W-1:0];
      p.first_y  = y0[COORD_W-1:0];
      p.second_x = x1[COORD_W-1:0];
      p.second_y = y1[COORD_W-1:0];
      corner_pairs = {corner_pairs, p};
   endtask

   task automatic add_random_pair();
      int x0, y0, x1, y1, d;
      x0 = $urandom_range(0, 65535);
      y0 = $urandom_range(0, 65535);
      x1 = $urandom_range(0, 65535);
      y1 = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: ;
         4: begin
            x1 = x0 + $urandom_range(0, 16) - 8;
            y1 = y0 + $urandom_range(0, 16) - 8;
         end
         5: y1 = y0;
         6: x1 = x0;
         7: begin
            x1 = x0;
            y1 = y0;
         end
         8: begin
            d  = $urandom_range(1, 4000);
            x1 = $urandom_range(0, 1) ? x0 + d : x0 - d;
            y1 = $urandom_range(0, 1) ? y0 + d : y0 - d;
         end
         default: begin
            y1 = y0 + $urandom_range(0, 6) - 3;
            x1 = x0 + $urandom_range(0, 6) - 3;
            if ($urandom_range(0, 1)) x1 = $urandom_range(0, 65535);
            else                     y1 = $urandom_range(0, 65535);
         end
      endcase
      add_pair(x0, y0, x1, y1);
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.first_x   = '0;
      req_chan.first_y   = '0;
      req_chan.second_x  = '0;
      req_chan.second_y  = '0;
      rsp_chan.ready     = 1'b0;

      // coincident corners
      add_pair(0, 0, 0, 0);
      add_pair(65535, 65535, 65535, 65535);
      add_pair(1234, 40000, 1234, 40000);
      // horizontal and vertical edges
      add_pair(0, 5, 65535, 5);
      add_pair(65535, 5, 0, 5);
      add_pair(7, 0, 7, 65535);
      add_pair(7, 65535, 7, 0);
      add_pair(100, 100, 101, 100);
      add_pair(101, 100, 100, 100);
      // diagonals in all four quadrants
      add_pair(0, 0, 100, 100);
      add_pair(100, 100, 0, 0);
      add_pair(0, 100, 100, 0);
      add_pair(100, 0, 0, 100);
      add_pair(0, 0, 65535, 65535);
      // steep, shallow and near the +-180 seam
      add_pair(0, 0, 65535, 1);
      add_pair(0, 0, 1, 65535);
      add_pair(65535, 65535, 0, 65534);
      add_pair(65535, 0, 0, 1);
      add_pair(1, 1, 0, 0);
      add_pair(0, 1, 1, 0);
      add_pair(65535, 0, 0, 65535);
      add_pair(0, 65535, 65535, 0);
      for (int n = 0; n < RANDOM_PAIRS; n++) add_random_pair();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (corner_pairs.size() != 0 || req_chan.valid || expected_angles.size() != 0)
         @(negedge clock);
      repeat (4 * PIPE_LATENCY) @(negedge clock);
      if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            next_pair.first_x  = req_chan.first_x;
            next_pair.first_y  = req_chan.first_y;
            next_pair.second_x = req_chan.second_x;
            next_pair.second_y = req_chan.second_y;
            expected_angles = {expected_angles, edge_angle(next_pair)};
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_chan.valid <= 1'b0;
            end else if (corner_pairs.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               idle_left = $urandom_range(1, 6) - 1;
               req_chan.valid <= 1'b0;
            end else begin
               next_pair = corner_pairs.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.first_x  <= next_pair.first_x;
               req_chan.first_y  <= next_pair.first_y;
               req_chan.second_x <= next_pair.second_x;
               req_chan.second_y <= next_pair.second_y;
            end
         end
         calm <= (corner_pairs.size() < CALM_TAIL);
      end
   end

   // response ready, with one long hold-off to back the pipe up
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         run_cycles++;
         if (run_cycles == HOLD_START) hold_left = HOLD_LEN;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected beat: angle %0d coincident %0b",
                        $signed(rsp_chan.angle), rsp_chan.coincident);
         end else begin
            if (rsp_chan.angle !== expected_angles[0].angle ||
                rsp_chan.coincident !== expected_angles[0].coincident) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch: angle exp %0d got %0d, coincident exp %0b got %0b",
                           $signed(expected_angles[0].angle), $signed(rsp_chan.angle),
                           expected_angles[0].coincident, rsp_chan.coincident);
            end
            void'(expected_angles.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule

[sim.f]
hdl/mea_pkg.sv
hdl/mea_req_if.sv
hdl/mea_rsp_if.sv
hdl/mea_prep.sv
hdl/mea_cell.sv
hdl/mea_finish.sv
hdl/marker_edge_angle_top.sv
tb/marker_edge_angle_top_tb.sv
